// ----- rtl/perot_pkg.sv -----
`timescale 1ns / 1ps

package perot_pkg;

    // word formats
    localparam int COORD_W = 32;
    localparam int ANGLE_W = 16;
    localparam int TRIG_W  = 16;

    // CORDIC set-up
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int CORDIC_ITERS  =
        (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    // atan(2^-i) in units of a full turn / 2^32
    localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // one CORDIC lane
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 flip;
    } cord_t;

    // offset and pivot travelling alongside the angle work
    typedef struct packed {
        logic signed [COORD_W:0]   dx;
        logic signed [COORD_W:0]   dy;
        logic signed [COORD_W:0]   dz;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic signed [COORD_W-1:0] oz;
    } geo_t;

    // Q30 CORDIC output to Q1.15, half up, saturated; flip negates first
    function automatic logic signed [TRIG_W-1:0] to_q15(
        input logic signed [CW-1:0] v,
        input logic                 flip
    );
        logic signed [CW:0] t;
        logic signed [CW:0] r;
        t = flip ? -(CW+1)'(v) : (CW+1)'(v);
        r = (t + (CW+1)'(1 << 14)) >>> 15;
        if (r > (CW+1)'(32767))
            to_q15 = 16'sh7FFF;
        else if (r < -(CW+1)'(32768))
            to_q15 = 16'sh8000;
        else
            to_q15 = r[TRIG_W-1:0];
    endfunction

endpackage

// ----- rtl/perot_in_if.sv -----
`timescale 1ns / 1ps

interface perot_in_if;
    import perot_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] pivot_x;
    logic signed [COORD_W-1:0] pivot_y;
    logic signed [COORD_W-1:0] pivot_z;
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;

    modport source (
        output valid, point_x, point_y, point_z, pivot_x, pivot_y, pivot_z,
               roll_angle, pitch_angle, yaw_angle,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, pivot_x, pivot_y, pivot_z,
               roll_angle, pitch_angle, yaw_angle,
        output ready
    );
endinterface

// ----- rtl/perot_out_if.sv -----
`timescale 1ns / 1ps

interface perot_out_if;
    import perot_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] rotated_x;
    logic signed [COORD_W-1:0] rotated_y;
    logic signed [COORD_W-1:0] rotated_z;

    modport source (
        output valid, rotated_x, rotated_y, rotated_z,
        input  ready
    );
    modport sink (
        input  valid, rotated_x, rotated_y, rotated_z,
        output ready
    );
endinterface

// ----- rtl/point_rotate_euler_about_origin.sv -----
`timescale 1ns / 1ps
// Channel   Dir   Word
// pt_in     in    point x/y/z, pivot x/y/z, roll/pitch/yaw angles
// pt_out    out   rotated x/y/z, Q16.16 saturated
//
// One word enters per cycle while the output stage is not stalled; the pipe is
// one CORDIC iteration per stage followed by the matrix build and
// multiply stages.
// Reset clears only the stage valid bits.
// A stall at the output freezes every stage at once; the last stage is the
// output register, so an empty output stage lets the pipe keep taking words.
module point_rotate_euler_about_origin (
    input  logic        clk,
    input  logic        rst_n,
    perot_in_if.sink    pt_in,
    perot_out_if.source pt_out
);
    import perot_pkg::*;

    localparam int N   = CORDIC_ITERS;
    localparam int LAT = N + 8;
    localparam int PW  = 48;            // matrix entry before rounding
    localparam int MW  = 32;            // Q.28 matrix entry
    localparam int XW  = MW + COORD_W + 1;
    localparam int AW  = XW + 2;

    // stage control
    logic           en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    assign en       = !vld_reg[LAT-1] || pt_out.ready;
    assign vld_next = {vld_reg[LAT-2:0], pt_in.valid};
    assign pt_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // geometry delay line
    geo_t geo_reg [0:LAT-2];
    geo_t geo_next;

    always_comb
    begin
        geo_next.dx = (COORD_W+1)'(pt_in.point_x) - (COORD_W+1)'(pt_in.pivot_x);
        geo_next.dy = (COORD_W+1)'(pt_in.point_y) - (COORD_W+1)'(pt_in.pivot_y);
        geo_next.dz = (COORD_W+1)'(pt_in.point_z) - (COORD_W+1)'(pt_in.pivot_z);
        geo_next.ox = pt_in.pivot_x;
        geo_next.oy = pt_in.pivot_y;
        geo_next.oz = pt_in.pivot_z;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_reg[0] <= geo_next;
            for (int k = 1; k < LAT-1; k++)
                geo_reg[k] <= geo_reg[k-1];
        end
    end

    // CORDIC: lane 0 roll, 1 pitch, 2 yaw
    cord_t cord_reg  [0:N][3];
    cord_t cord_next [0:N][3];
    logic signed [ANGLE_W-1:0] ang [3];

    assign ang[0] = pt_in.roll_angle;
    assign ang[1] = pt_in.pitch_angle;
    assign ang[2] = pt_in.yaw_angle;

    // quadrant fold into +/- a quarter turn
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            cord_next[0][a].x    = CORDIC_GAIN;
            cord_next[0][a].y    = '0;
            cord_next[0][a].z    = CW'(ang[a]) <<< 16;
            cord_next[0][a].flip = 1'b0;
            if (ang[a][ANGLE_W-1:ANGLE_W-2] == 2'b01)
            begin
                cord_next[0][a].z    = (CW'(ang[a]) <<< 16) - (CW'(1) <<< 31);
                cord_next[0][a].flip = 1'b1;
            end
            else if (ang[a][ANGLE_W-1:ANGLE_W-2] == 2'b10)
            begin
                cord_next[0][a].z    = (CW'(ang[a]) <<< 16) + (CW'(1) <<< 31);
                cord_next[0][a].flip = 1'b1;
            end
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < N; i++)
    begin : g_cordic
        always_comb
        begin
            for (int a = 0; a < 3; a++)
            begin
                cord_next[i+1][a].flip = cord_reg[i][a].flip;
                if (!cord_reg[i][a].z[CW-1])
                begin
                    cord_next[i+1][a].x = cord_reg[i][a].x - (cord_reg[i][a].y >>> i);
                    cord_next[i+1][a].y = cord_reg[i][a].y + (cord_reg[i][a].x >>> i);
                    cord_next[i+1][a].z = cord_reg[i][a].z
                                        - $signed({2'b00, ATAN_TAB[i]});
                end
                else
                begin
                    cord_next[i+1][a].x = cord_reg[i][a].x + (cord_reg[i][a].y >>> i);
                    cord_next[i+1][a].y = cord_reg[i][a].y - (cord_reg[i][a].x >>> i);
                    cord_next[i+1][a].z = cord_reg[i][a].z
                                        + $signed({2'b00, ATAN_TAB[i]});
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= N; k++)
                for (int a = 0; a < 3; a++)
                    cord_reg[k][a] <= cord_next[k][a];
        end
    end

    // sine / cosine to Q1.15
    logic signed [TRIG_W-1:0] sin_reg [3];
    logic signed [TRIG_W-1:0] cos_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sin_reg[a] <= to_q15(cord_reg[N][a].y, cord_reg[N][a].flip);
                cos_reg[a] <= to_q15(cord_reg[N][a].x, cord_reg[N][a].flip);
            end
        end
    end

    // pair products
    logic signed [31:0] cpcy_reg, cpsy_reg, crsy_reg, crcy_reg, srsp_reg;
    logic signed [31:0] srsy_reg, srcy_reg, crcp_reg, srcp_reg, crsp_reg;
    logic signed [TRIG_W-1:0] sp2_reg, cy2_reg, sy2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cpcy_reg <= 32'(cos_reg[1]) * 32'(cos_reg[2]);
            cpsy_reg <= 32'(cos_reg[1]) * 32'(sin_reg[2]);
            crsy_reg <= 32'(cos_reg[0]) * 32'(sin_reg[2]);
            crcy_reg <= 32'(cos_reg[0]) * 32'(cos_reg[2]);
            srsp_reg <= 32'(sin_reg[0]) * 32'(sin_reg[1]);
            srsy_reg <= 32'(sin_reg[0]) * 32'(sin_reg[2]);
            srcy_reg <= 32'(sin_reg[0]) * 32'(cos_reg[2]);
            crcp_reg <= 32'(cos_reg[0]) * 32'(cos_reg[1]);
            srcp_reg <= 32'(sin_reg[0]) * 32'(cos_reg[1]);
            crsp_reg <= 32'(cos_reg[0]) * 32'(sin_reg[1]);
            sp2_reg  <= sin_reg[1];
            cy2_reg  <= cos_reg[2];
            sy2_reg  <= sin_reg[2];
        end
    end

    // triple products; single-pair terms scaled by the missing unity factor
    logic signed [PW-1:0] eb_reg [3][3];
    logic signed [PW-1:0] tp_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eb_reg[0][0] <= PW'(cpcy_reg) <<< 15;
            eb_reg[0][1] <= -(PW'(cpsy_reg) <<< 15);
            eb_reg[0][2] <= PW'(sp2_reg) <<< 30;
            eb_reg[1][0] <= PW'(crsy_reg) <<< 15;
            eb_reg[1][1] <= PW'(crcy_reg) <<< 15;
            eb_reg[1][2] <= -(PW'(srcp_reg) <<< 15);
            eb_reg[2][0] <= PW'(srsy_reg) <<< 15;
            eb_reg[2][1] <= PW'(srcy_reg) <<< 15;
            eb_reg[2][2] <= PW'(crcp_reg) <<< 15;
            tp_reg[0]    <= PW'(srsp_reg) * PW'(cy2_reg);
            tp_reg[1]    <= PW'(srsp_reg) * PW'(sy2_reg);
            tp_reg[2]    <= PW'(crsp_reg) * PW'(cy2_reg);
            tp_reg[3]    <= PW'(crsp_reg) * PW'(sy2_reg);
        end
    end

    // matrix entries, rounded half up to Q.28
    logic signed [PW-1:0] e_sum [3][3];
    logic signed [PW-1:0] e_rnd [3][3];
    logic signed [MW-1:0] m_reg [3][3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                e_sum[r][c] = eb_reg[r][c];
        e_sum[1][0] = eb_reg[1][0] + tp_reg[0];
        e_sum[1][1] = eb_reg[1][1] - tp_reg[1];
        e_sum[2][0] = eb_reg[2][0] - tp_reg[2];
        e_sum[2][1] = eb_reg[2][1] + tp_reg[3];
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                e_rnd[r][c] = (e_sum[r][c] + PW'(1 << 16)) >>> 17;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    m_reg[r][c] <= e_rnd[r][c][MW-1:0];
        end
    end

    // entry times offset
    logic signed [COORD_W:0] d_vec [3];
    logic signed [XW-1:0]    pr_reg [3][3];

    assign d_vec[0] = geo_reg[N+4].dx;
    assign d_vec[1] = geo_reg[N+4].dy;
    assign d_vec[2] = geo_reg[N+4].dz;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    pr_reg[r][c] <= XW'(m_reg[r][c]) * XW'(d_vec[c]);
        end
    end

    // row sums
    logic signed [AW-1:0] acc_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                acc_reg[r] <= AW'(pr_reg[r][0]) + AW'(pr_reg[r][1]) + AW'(pr_reg[r][2]);
        end
    end

    // round, add pivot back, saturate
    logic signed [COORD_W-1:0] o_vec [3];
    logic signed [AW-1:0]      rnd   [3];
    logic signed [COORD_W-1:0] res_next [3];
    logic signed [COORD_W-1:0] res_reg  [3];

    assign o_vec[0] = geo_reg[LAT-2].ox;
    assign o_vec[1] = geo_reg[LAT-2].oy;
    assign o_vec[2] = geo_reg[LAT-2].oz;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            rnd[r] = ((acc_reg[r] + AW'(1 << 27)) >>> 28) + AW'(o_vec[r]);
            if (rnd[r] > AW'(32'sh7FFFFFFF))
                res_next[r] = 32'sh7FFFFFFF;
            else if (rnd[r] < AW'(32'sh80000000))
                res_next[r] = 32'sh80000000;
            else
                res_next[r] = rnd[r][COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                res_reg[r] <= res_next[r];
        end
    end

    assign pt_out.valid     = vld_reg[LAT-1];
    assign pt_out.rotated_x = res_reg[0];
    assign pt_out.rotated_y = res_reg[1];
    assign pt_out.rotated_z = res_reg[2];

    // checks
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        pt_in.ready == (!vld_reg[LAT-1] || pt_out.ready))
        else $error("input ready does not follow output stage");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (pt_in.valid && pt_in.ready) |=> vld_reg[0])
        else $error("accepted word not in first stage");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("stage valids moved during stall");

endmodule

// ----- test/point_rotate_euler_about_origin_tb.sv -----
`timescale 1ns / 1ps

module point_rotate_euler_about_origin_tb;
    import perot_pkg::*;

    localparam int LATENCY = CORDIC_ITERS + 8;

    // one input word and its rotated result
    typedef struct {
        logic signed [COORD_W-1:0] px, py, pz, ox, oy, oz;
        logic signed [ANGLE_W-1:0] roll, pitch, yaw;
    } pose_word_t;

    typedef struct {
        logic signed [COORD_W-1:0] x, y, z;
    } rot_word_t;

    // atan(2^-i), full turn / 2^32
    localparam longint ATAN_TURN [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    // arithmetic shift on longint rounds towards minus infinity
    function automatic longint q15_round(longint v);
        longint r;
        r = (v + (64'sd1 <<< 14)) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    function automatic void trig_of(input logic signed [ANGLE_W-1:0] a,
                                    output longint s, output longint c);
        longint z, x, y, nx;
        bit     neg;
        z = longint'(a) * 65536;
        x = 652032874;
        y = 0;
        neg = 0;
        if (z >= (64'sd1 <<< 30)) begin
            z -= (64'sd1 <<< 31);
            neg = 1;
        end else if (z < -(64'sd1 <<< 30)) begin
            z += (64'sd1 <<< 31);
            neg = 1;
        end
        for (int i = 0; i < CORDIC_ITERS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= ATAN_TURN[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += ATAN_TURN[i];
            end
            x = nx;
        end
        if (neg) begin
            x = -x;
            y = -y;
        end
        c = q15_round(x);
        s = q15_round(y);
    endfunction

    function automatic rot_word_t rotate_point(pose_word_t w);
        longint sr, cr, sp, cp, sy, cy, acc, v;
        longint m [3][3];
        longint d [3];
        longint o [3];
        longint e [3][3];
        rot_word_t r;
        trig_of(w.roll, sr, cr);
        trig_of(w.pitch, sp, cp);
        trig_of(w.yaw, sy, cy);
        o = '{longint'(w.ox), longint'(w.oy), longint'(w.oz)};
        d = '{longint'(w.px) - o[0], longint'(w.py) - o[1], longint'(w.pz) - o[2]};
        e[0][0] = cp * cy * 32768;
        e[0][1] = -cp * sy * 32768;
        e[0][2] = sp * 32768 * 32768;
        e[1][0] = cr * sy * 32768 + sr * sp * cy;
        e[1][1] = cr * cy * 32768 - sr * sp * sy;
        e[1][2] = -sr * cp * 32768;
        e[2][0] = sr * sy * 32768 - cr * sp * cy;
        e[2][1] = sr * cy * 32768 + cr * sp * sy;
        e[2][2] = cr * cp * 32768;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = (e[i][j] + (64'sd1 <<< 16)) >>> 17;
        for (int i = 0; i < 3; i++)
        begin
            acc = m[i][0] * d[0] + m[i][1] * d[1] + m[i][2] * d[2];
            v = ((acc + (64'sd1 <<< 27)) >>> 28) + o[i];
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            if (i == 0) r.x = v[31:0];
            else if (i == 1) r.y = v[31:0];
            else r.z = v[31:0];
        end
        return r;
    endfunction

    // expected rotated points in order of acceptance
    class rotation_board;
        rot_word_t pending [$];
        int        errors;
        int        matched;

        function void note_pose(pose_word_t w);
            pending.push_back(rotate_point(w));
        endfunction

        function void check_point(rot_word_t got);
            rot_word_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h %h %h", $time, got.x, got.y, got.z);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x) begin
                $display("%0t: rotated_x expected %h got %h", $time, want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $display("%0t: rotated_y expected %h got %h", $time, want.y, got.y);
                errors++;
            end
            if (got.z !== want.z) begin
                $display("%0t: rotated_z expected %h got %h", $time, want.z, got.z);
                errors++;
            end
            matched++;
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    perot_in_if  pt_in ();
    perot_out_if pt_out ();

    point_rotate_euler_about_origin DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .pt_in (pt_in.sink),
        .pt_out(pt_out.source)
    );

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    rotation_board board = new();
    int send_idle_pct = 35;
    int recv_idle_pct = 75;
    int sent = 0;

    // receiver: random back-pressure, sample on rising edge
    always @(negedge clk)
        pt_out.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
        if (rst_n && pt_out.valid && pt_out.ready)
            board.check_point('{pt_out.rotated_x, pt_out.rotated_y, pt_out.rotated_z});

    // hold one word until accepted, with random idle cycles before it;
    // valid stays high afterwards so words can follow back to back
    task automatic send_pose(pose_word_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pt_in.valid <= 0;
            @(negedge clk);
        end
        pt_in.valid       <= 1;
        pt_in.point_x     <= w.px;
        pt_in.point_y     <= w.py;
        pt_in.point_z     <= w.pz;
        pt_in.pivot_x     <= w.ox;
        pt_in.pivot_y     <= w.oy;
        pt_in.pivot_z     <= w.oz;
        pt_in.roll_angle  <= w.roll;
        pt_in.pitch_angle <= w.pitch;
        pt_in.yaw_angle   <= w.yaw;
        do @(posedge clk); while (!pt_in.ready);
        board.note_pose(w);
        sent++;
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            // near the quarter turns, where the half-turn fold kicks in
            2: return {2'($urandom_range(3)), 14'd0} + 16'($urandom_range(4)) - 16'd2;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic pose_word_t rand_pose();
        pose_word_t w;
        w.px = rand_coord(); w.py = rand_coord(); w.pz = rand_coord();
        w.ox = rand_coord(); w.oy = rand_coord(); w.oz = rand_coord();
        w.roll = rand_angle(); w.pitch = rand_angle(); w.yaw = rand_angle();
        return w;
    endfunction

    task automatic drain();
        while (board.pending.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        localparam logic [31:0] MAXC = 32'h7FFFFFFF;
        localparam logic [31:0] MINC = 32'h80000000;
        logic [15:0] angs [7];
        pose_word_t  w;
        angs = '{16'h0000, 16'h4000, 16'hC000, 16'h8000, 16'h7FFF, 16'h3FFF, 16'h2000};
        pt_in.valid = 0;
        pt_in.point_x = 0; pt_in.point_y = 0; pt_in.point_z = 0;
        pt_in.pivot_x = 0; pt_in.pivot_y = 0; pt_in.pivot_z = 0;
        pt_in.roll_angle = 0; pt_in.pitch_angle = 0; pt_in.yaw_angle = 0;
        pt_out.ready = 0;
        repeat (8) @(negedge clk);
        rst_n = 1;

        // directed: special angles on each axis, offset overflow, saturation
        for (int i = 0; i < 7; i++)
        begin
            send_pose('{32'h00010000, 32'h00020000, 32'h00030000, 0, 0, 0,
                        angs[i], angs[(i + 2) % 7], angs[(i + 4) % 7]});
        end
        send_pose('{MAXC, MAXC, MAXC, MINC, MINC, MINC, 16'h0000, 16'h0000, 16'h0000});
        send_pose('{MINC, MINC, MINC, MAXC, MAXC, MAXC, 16'h8000, 16'h8000, 16'h8000});
        send_pose('{MAXC, MINC, MAXC, MINC, MAXC, MINC, 16'h2000, 16'h6000, 16'hA000});
        send_pose('{MAXC, MAXC, MINC, 0, 0, 0, 16'h1000, 16'h4000, 16'hE000});
        send_pose('{MINC, MAXC, 0, MAXC, MINC, 0, 16'h7FFF, 16'h8001, 16'h4000});
        send_pose('{32'hFFFFFFFF, 32'h1, 32'h0, 32'h1, 32'hFFFFFFFF, 32'h0,
                    16'h5555, 16'hAAAA, 16'h0001});

        // sender pauses until the pipe is empty
        pt_in.valid <= 0;
        drain();

        // random, in three idling regimes
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 75 : 0;
            recv_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 35 : 0;
            for (int n = 0; n < 500; n++)
            begin
                w = rand_pose();
                send_pose(w);
            end
        end

        pt_in.valid <= 0;
        drain();
        repeat (LATENCY + 10) @(negedge clk);
        $display("Sent %0d points over three flow-control regimes; %0d results checked.",
                 sent, board.matched);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
